@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define AMD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset
`define AMD_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ rtl/amd_pkg.sv @@
// ----------------------------------------------------------------------------
// amd_pkg
// Types and constants shared by the moving-average duty-map block.
// ----------------------------------------------------------------------------
package amd_pkg;

    // Window and field widths
    localparam int WINDOW   = 8;
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 13;
    localparam int DUTY_W   = 10;
    localparam int SUM_W    = SAMPLE_W + SLOT_W;

    // Divider datapath widths
    localparam int NUM_W    = SUM_W + MV_W;
    localparam int DEN_W    = FILL_W + SAMPLE_W;
    localparam int REM_W    = DEN_W + 1;
    localparam int LVL_Q    = MV_W;
    localparam int DUTY_Q   = DUTY_W;
    localparam int STEP_W   = $clog2(LVL_Q + 1);

    // Arithmetic constants
    localparam logic [SAMPLE_W-1:0] ADC_MAX   = 12'd4095;
    localparam logic [DUTY_W-1:0]   DUTY_FULL = 10'd1000;

    // Register map
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [1:0] REG_LOWER      = 2'd1;
    localparam logic [1:0] REG_UPPER      = 2'd2;
    localparam logic [MV_W-1:0] FULL_SCALE_RST = 13'd3300;
    localparam logic [MV_W-1:0] LOWER_RST      = 13'd1500;
    localparam logic [MV_W-1:0] UPPER_RST      = 13'd2800;

    // Job queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_LVL,
        BK_MAP,
        BK_DIV_DUTY,
        BK_DONE
    } back_state_t;

endpackage

@@ rtl/adc_moving_average_duty_map.sv @@
// Each sample is filtered in the front end, queued, and divided by the single shared
// restoring divider: 13 level steps, then 10 duty steps on the linear duty branch;
// the duty divide is skipped when the duty clamps to 0 or 1000. The front end can
// accept a new sample while the divider works, until the two-entry job queue is full.
// Reset: rst_n clears sum, fill count, slot, queue and handshake state;
// registers return to 3300 / 1500 / 2800 mV. No clearing pass is needed.
// ----------------------------------------------------------------------------
// adc_moving_average_duty_map
// ADC moving-average filter with millivolt scaling and clamped duty mapping.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_moving_average_duty_map (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [amd_pkg::SAMPLE_W-1:0]  sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [amd_pkg::MV_W-1:0]      level_mv,
    output logic [amd_pkg::DUTY_W-1:0]    duty_permille,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [amd_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [amd_pkg::MV_W-1:0] full_scale_reg;
    logic [amd_pkg::MV_W-1:0] lower_reg;
    logic [amd_pkg::MV_W-1:0] upper_reg;
    logic                     cfg_wr;

    logic                 push;
    logic                 pop;
    amd_pkg::div_job_t    push_job;
    amd_pkg::div_job_t    pop_job;
    amd_pkg::fifo_stat_t  fifo_stat;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= amd_pkg::FULL_SCALE_RST;
            lower_reg      <= amd_pkg::LOWER_RST;
            upper_reg      <= amd_pkg::UPPER_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                amd_pkg::REG_FULL_SCALE: full_scale_reg <= pwdata[amd_pkg::MV_W-1:0];
                amd_pkg::REG_LOWER:      lower_reg      <= pwdata[amd_pkg::MV_W-1:0];
                amd_pkg::REG_UPPER:      upper_reg      <= pwdata[amd_pkg::MV_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[3:2])
            amd_pkg::REG_FULL_SCALE: prdata = 32'(full_scale_reg);
            amd_pkg::REG_LOWER:      prdata = 32'(lower_reg);
            amd_pkg::REG_UPPER:      prdata = 32'(upper_reg);
            default:                 prdata = '0;
        endcase
    end

    // Front end: ring, sum, job build
    amd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .full_scale_mv (full_scale_reg),
        .push          (push),
        .push_job      (push_job),
        .fifo_full     (fifo_stat.full)
    );

    // Job queue
    amd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (fifo_stat)
    );

    // Back end: divider and duty map
    amd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .stat          (fifo_stat),
        .pop_job       (pop_job),
        .pop           (pop),
        .lower_mv      (lower_reg),
        .upper_mv      (upper_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level_mv      (level_mv),
        .duty_permille (duty_permille)
    );

    // Checks
    `AMD_ASSERT(a_duty_range, clk, rst_n, out_valid |-> (duty_permille <= 10'd1000))
    `AMD_ASSERT(a_level_range, clk, rst_n, out_valid |-> (level_mv <= full_scale_reg))
    `AMD_ASSERT_NEVER(a_queue_overflow, clk, rst_n, push && fifo_stat.full)
    `AMD_ASSERT_NEVER(a_queue_underflow, clk, rst_n, pop && fifo_stat.empty)

endmodule

@@ rtl/amd_fifo.sv @@
// ----------------------------------------------------------------------------
// amd_fifo
// Short job queue between the sample front end and the divider back end.
// ----------------------------------------------------------------------------
module amd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  amd_pkg::div_job_t  push_job,
    input  logic               pop,
    output amd_pkg::div_job_t  pop_job,
    output amd_pkg::fifo_stat_t stat
);

    amd_pkg::div_job_t mem [amd_pkg::FIFO_DEPTH];

    logic [amd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [amd_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [amd_pkg::FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign pop_job    = mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == amd_pkg::FIFO_CNT_W'(amd_pkg::FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == amd_pkg::FIFO_PTR_W'(amd_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == amd_pkg::FIFO_PTR_W'(amd_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/amd_front.sv @@
// ----------------------------------------------------------------------------
// amd_front
// Sample ring, running sum and fill count; builds one divide job per beat.
// ----------------------------------------------------------------------------
module amd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [amd_pkg::SAMPLE_W-1:0]  sample,
    input  logic [amd_pkg::MV_W-1:0]      full_scale_mv,
    output logic                          push,
    output amd_pkg::div_job_t             push_job,
    input  logic                          fifo_full
);

    logic [amd_pkg::SAMPLE_W-1:0] ring_mem [amd_pkg::WINDOW];

    logic [amd_pkg::SUM_W-1:0]  sum_reg,  sum_next;
    logic [amd_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [amd_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic                       pend_reg, pend_next;

    logic                         accept;
    logic                         ring_full;
    logic [amd_pkg::SAMPLE_W-1:0] old_sample;

    assign in_ready   = !pend_reg;
    assign accept     = in_valid && in_ready;
    assign ring_full  = (fill_reg == amd_pkg::FILL_W'(amd_pkg::WINDOW));
    assign old_sample = ring_mem[slot_reg];

    // Ring write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[slot_reg] <= sample;
        end
    end

    // Running sum, slot and fill update
    always_comb
    begin
        sum_next  = sum_reg;
        slot_next = slot_reg;
        fill_next = fill_reg;
        pend_next = pend_reg;
        if (accept)
        begin
            sum_next  = sum_reg - (ring_full ? amd_pkg::SUM_W'(old_sample) : '0)
                      + amd_pkg::SUM_W'(sample);
            slot_next = (slot_reg == amd_pkg::SLOT_W'(amd_pkg::WINDOW - 1))
                      ? '0 : slot_reg + 1'b1;
            if (!ring_full)
            begin
                fill_next = fill_reg + 1'b1;
            end
            pend_next = 1'b1;
        end
        else if (push)
        begin
            pend_next = 1'b0;
        end
    end

    // Job: numerator sum*full_scale, denominator fill*4095
    assign push          = pend_reg && !fifo_full;
    assign push_job.num  = amd_pkg::NUM_W'(sum_reg) * amd_pkg::NUM_W'(full_scale_mv);
    assign push_job.den  = amd_pkg::DEN_W'(fill_reg) * amd_pkg::DEN_W'(amd_pkg::ADC_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

endmodule

@@ rtl/amd_back.sv @@
// ----------------------------------------------------------------------------
// amd_back
// Shared restoring divider: level in millivolts, then the duty mapping.
// ----------------------------------------------------------------------------
module amd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  amd_pkg::fifo_stat_t         stat,
    input  amd_pkg::div_job_t           pop_job,
    output logic                        pop,
    input  logic [amd_pkg::MV_W-1:0]    lower_mv,
    input  logic [amd_pkg::MV_W-1:0]    upper_mv,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [amd_pkg::MV_W-1:0]    level_mv,
    output logic [amd_pkg::DUTY_W-1:0]  duty_permille
);

    amd_pkg::back_state_t state_reg, state_next;

    logic [amd_pkg::REM_W-1:0]  rem_reg,   rem_next;
    logic [amd_pkg::NUM_W-1:0]  nsh_reg,   nsh_next;
    logic [amd_pkg::DEN_W-1:0]  den_reg,   den_next;
    logic [amd_pkg::MV_W-1:0]   quo_reg,   quo_next;
    logic [amd_pkg::STEP_W-1:0] step_reg,  step_next;
    logic [amd_pkg::MV_W-1:0]   level_reg, level_next;
    logic [amd_pkg::DUTY_W-1:0] duty_reg,  duty_next;
    logic                       out_valid_reg, out_valid_next;
    logic [amd_pkg::MV_W-1:0]   out_level_reg, out_level_next;
    logic [amd_pkg::DUTY_W-1:0] out_duty_reg,  out_duty_next;

    logic [amd_pkg::REM_W-1:0]  rem_sh;
    logic [amd_pkg::REM_W-1:0]  rem_step;
    logic                       q_bit;
    logic [amd_pkg::MV_W-1:0]   diff;
    logic [amd_pkg::NUM_W-1:0]  prod;
    logic                       load_out;

    // One divider step: shift in next numerator bit, trial subtract
    assign rem_sh   = {rem_reg[amd_pkg::REM_W-2:0], nsh_reg[amd_pkg::NUM_W-1]};
    assign q_bit    = (rem_sh >= amd_pkg::REM_W'(den_reg));
    assign rem_step = q_bit ? rem_sh - amd_pkg::REM_W'(den_reg) : rem_sh;

    // Span numerator for the linear branch
    assign diff = level_reg - lower_mv;
    assign prod = amd_pkg::NUM_W'(diff) * amd_pkg::NUM_W'(amd_pkg::DUTY_FULL);

    assign out_valid     = out_valid_reg;
    assign level_mv      = out_level_reg;
    assign duty_permille = out_duty_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        nsh_next       = nsh_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        level_next     = level_reg;
        duty_next      = duty_reg;
        out_level_next = out_level_reg;
        out_duty_next  = out_duty_reg;
        pop            = 1'b0;
        load_out       = 1'b0;

        unique case (state_reg)
            amd_pkg::BK_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop        = 1'b1;
                    // quotient fits LVL_Q bits, so the high part is below den
                    rem_next   = amd_pkg::REM_W'(pop_job.num >> amd_pkg::LVL_Q);
                    nsh_next   = pop_job.num << (amd_pkg::NUM_W - amd_pkg::LVL_Q);
                    den_next   = pop_job.den;
                    quo_next   = '0;
                    step_next  = amd_pkg::STEP_W'(amd_pkg::LVL_Q);
                    state_next = amd_pkg::BK_DIV_LVL;
                end
            end
            amd_pkg::BK_DIV_LVL:
            begin
                if (step_reg != '0)
                begin
                    rem_next  = rem_step;
                    nsh_next  = nsh_reg << 1;
                    quo_next  = {quo_reg[amd_pkg::MV_W-2:0], q_bit};
                    step_next = step_reg - 1'b1;
                end
                else
                begin
                    level_next = quo_reg;
                    state_next = amd_pkg::BK_MAP;
                end
            end
            amd_pkg::BK_MAP:
            begin
                if (level_reg < lower_mv)
                begin
                    duty_next  = '0;
                    state_next = amd_pkg::BK_DONE;
                end
                else if (level_reg >= upper_mv)
                begin
                    duty_next  = amd_pkg::DUTY_FULL;
                    state_next = amd_pkg::BK_DONE;
                end
                else
                begin
                    rem_next   = amd_pkg::REM_W'(prod >> amd_pkg::DUTY_Q);
                    nsh_next   = prod << (amd_pkg::NUM_W - amd_pkg::DUTY_Q);
                    den_next   = amd_pkg::DEN_W'(upper_mv - lower_mv);
                    quo_next   = '0;
                    step_next  = amd_pkg::STEP_W'(amd_pkg::DUTY_Q);
                    state_next = amd_pkg::BK_DIV_DUTY;
                end
            end
            amd_pkg::BK_DIV_DUTY:
            begin
                if (step_reg != '0)
                begin
                    rem_next  = rem_step;
                    nsh_next  = nsh_reg << 1;
                    quo_next  = {quo_reg[amd_pkg::MV_W-2:0], q_bit};
                    step_next = step_reg - 1'b1;
                end
                else
                begin
                    duty_next  = quo_reg[amd_pkg::DUTY_W-1:0];
                    state_next = amd_pkg::BK_DONE;
                end
            end
            amd_pkg::BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_level_next = level_reg;
                    out_duty_next  = duty_reg;
                    state_next     = amd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = amd_pkg::BK_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amd_pkg::BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        nsh_reg       <= nsh_next;
        den_reg       <= den_next;
        quo_reg       <= quo_next;
        level_reg     <= level_next;
        duty_reg      <= duty_next;
        out_level_reg <= out_level_next;
        out_duty_reg  <= out_duty_next;
    end

endmodule

@@ test/duty_map_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duty_map_checker
// Watches the sample, reading and register channels of the moving-average
// duty-map block. Keeps its own copy of the filter state and the thresholds,
// predicts the level and duty for each sample beat and compares every reading
// beat against the oldest prediction.
// ----------------------------------------------------------------------------
module duty_map_checker
    import amd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [MV_W-1:0]     level_mv,
    input  logic [DUTY_W-1:0]   duty_permille,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output int                  mismatches,
    output int                  pending,
    output int                  readings_checked
);

    typedef struct packed {
        logic [MV_W-1:0]   level;
        logic [DUTY_W-1:0] duty;
    } reading_t;

    reading_t predicted_readings[$];

    // Shadow of the filter state and the register file
    logic [SAMPLE_W-1:0] ring_copy [WINDOW];
    logic [SUM_W-1:0]    sum_copy;
    logic [SLOT_W-1:0]   slot_copy;
    logic [FILL_W-1:0]   fill_copy;
    logic [MV_W-1:0]     scale_mv;
    logic [MV_W-1:0]     low_mv;
    logic [MV_W-1:0]     high_mv;

    initial
    begin
        mismatches       = 0;
        pending          = 0;
        readings_checked = 0;
    end

    // Push one sample into the window and work out the reading it produces
    function automatic reading_t filter_and_map(input logic [SAMPLE_W-1:0] s);
        longint unsigned num;
        longint unsigned den;
        longint unsigned part;
        longint unsigned span;
        reading_t        r;
        if (fill_copy < WINDOW)
            fill_copy = fill_copy + 1'b1;
        else
            sum_copy = sum_copy - ring_copy[slot_copy];
        ring_copy[slot_copy] = s;
        sum_copy  = sum_copy + s;
        slot_copy = (slot_copy == SLOT_W'(WINDOW - 1)) ? '0 : slot_copy + 1'b1;

        // level = sum * full scale / (count * 4095), truncated
        num = sum_copy;
        num = num * scale_mv;
        den = fill_copy;
        den = den * ADC_MAX;
        r.level = MV_W'(num / den);

        // clamp below lower, linear up to upper, full at or above upper
        if (r.level < low_mv)
            r.duty = '0;
        else if (r.level < high_mv)
        begin
            part   = r.level - low_mv;
            span   = high_mv - low_mv;
            r.duty = DUTY_W'((part * DUTY_FULL) / span);
        end
        else
            r.duty = DUTY_FULL;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            predicted_readings.delete();
            foreach (ring_copy[i])
                ring_copy[i] = '0;
            sum_copy  = '0;
            slot_copy = '0;
            fill_copy = '0;
            scale_mv  = FULL_SCALE_RST;
            low_mv    = LOWER_RST;
            high_mv   = UPPER_RST;
            pending   = 0;
        end
        else
        begin
            // reading beat: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (predicted_readings.size() == 0)
                begin
                    $error("reading beat with no sample pending: level_mv %0d duty_permille %0d",
                           level_mv, duty_permille);
                    mismatches++;
                end
                else
                begin
                    want = predicted_readings.pop_front();
                    readings_checked++;
                    if (level_mv !== want.level)
                    begin
                        $error("level_mv: expected %0d, got %0d", want.level, level_mv);
                        mismatches++;
                    end
                    if (duty_permille !== want.duty)
                    begin
                        $error("duty_permille: expected %0d, got %0d", want.duty, duty_permille);
                        mismatches++;
                    end
                end
            end

            // sample beat: advance the shadow filter
            if (in_valid && in_ready)
                predicted_readings.push_back(filter_and_map(sample));

            // register write; unknown index is dropped
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_FULL_SCALE: scale_mv = pwdata[MV_W-1:0];
                    REG_LOWER:      low_mv   = pwdata[MV_W-1:0];
                    REG_UPPER:      high_mv  = pwdata[MV_W-1:0];
                    default:        ;
                endcase
            end

            pending = predicted_readings.size();
        end
    end

endmodule

@@ test/tb_adc_moving_average_duty_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_moving_average_duty_map
// Drives ADC samples and register writes into the moving-average duty-map
// block under random source gaps and sink stalls. A directed warm-up comes
// first, then random sample runs aimed at the thresholds under a series of
// scale and threshold settings; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_adc_moving_average_duty_map;
    import amd_pkg::*;

    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam int         IDLE_PCT       = 22;
    localparam int         QUIET_LIMIT    = 4000;
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         DRAIN_CYCLES   = 60;
    localparam int         FIXED_SETTINGS = 6;
    localparam int         RANDOM_SETTINGS = 4;
    localparam int         RANDOM_RUN_LEN = 130;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [MV_W-1:0]     level_mv;
    logic [DUTY_W-1:0]   duty_permille;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    logic steady = 1'b0;
    logic in_beat = 1'b0;
    int   quiet_cycles = 0;
    int   mismatches;
    int   pending;
    int   readings_checked;
    int   samples_sent = 0;
    int   settings_used = 1;

    logic [MV_W-1:0] cur_scale = FULL_SCALE_RST;
    logic [MV_W-1:0] cur_low   = LOWER_RST;
    logic [MV_W-1:0] cur_high  = UPPER_RST;

    // Fixed settings: full range, zero scale, inverted, tiny scale with
    // top lower threshold, equal thresholds, unity scale
    logic [MV_W-1:0] fixed_scale [FIXED_SETTINGS] =
        '{13'd8191, 13'd0, 13'd5000, 13'd1, 13'd3300, 13'd4095};
    logic [MV_W-1:0] fixed_low [FIXED_SETTINGS] =
        '{13'd0, 13'd0, 13'd3000, 13'd8191, 13'd2000, 13'd1};
    logic [MV_W-1:0] fixed_high [FIXED_SETTINGS] =
        '{13'd8191, 13'd0, 13'd1000, 13'd0, 13'd2000, 13'd8190};
    int fixed_count [FIXED_SETTINGS] = '{150, 60, 150, 60, 150, 150};

    logic [SAMPLE_W-1:0] warmup [8] =
        '{12'd4095, 12'd0, 12'hAAA, 12'h555, 12'd1, 12'd4094, 12'd2048, 12'd2047};

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    adc_moving_average_duty_map u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level_mv      (level_mv),
        .duty_permille (duty_permille),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    duty_map_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .level_mv         (level_mv),
        .duty_permille    (duty_permille),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .mismatches       (mismatches),
        .pending          (pending),
        .readings_checked (readings_checked)
    );

    // Sink stalls
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Registered sample handshake, read by the driver at the falling edge
    always @(posedge clk)
        in_beat <= in_valid && in_ready;

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_adc_moving_average_duty_map: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One sample beat, with a random gap ahead of it
    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(negedge clk);
        while (!in_beat);
        samples_sent++;
    endtask

    // Hold the source until every reading has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [MV_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [MV_W-1:0] fs, input logic [MV_W-1:0] lo,
                                 input logic [MV_W-1:0] hi);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_FULL_SCALE, fs);
        write_reg(REG_LOWER, lo);
        write_reg(REG_UPPER, hi);
        cur_scale = fs;
        cur_low   = lo;
        cur_high  = hi;
        settings_used++;
    endtask

    // Sample whose settled level lands on or next to a threshold, or at a random level
    function automatic logic [SAMPLE_W-1:0] aim_sample();
        int unsigned target;
        int unsigned s;
        case ($urandom_range(0, 4))
            0:       target = cur_low;
            1:       target = cur_high;
            2:       target = cur_low + 1;
            3:       target = (cur_high > 0) ? cur_high - 1 : 0;
            default: target = $urandom_range(0, cur_scale);
        endcase
        if (cur_scale == 0)
            return SAMPLE_W'($urandom_range(0, 4095));
        s = (target * 4095 + cur_scale - 1) / cur_scale;
        if (s > 4095)
            s = 4095;
        return SAMPLE_W'(s);
    endfunction

    // Mostly settling runs, some extremes and uniform noise
    task automatic random_samples(input int count);
        int                  sent;
        int                  run_len;
        logic [SAMPLE_W-1:0] base;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    base    = aim_sample();
                    run_len = $urandom_range(8, 12);
                    for (int k = 0; k < run_len && sent < count; k++)
                    begin
                        push_sample(($urandom_range(0, 3) == 0 && base < ADC_MAX) ?
                                    base + 1'b1 : base);
                        sent++;
                    end
                end
                5:
                begin
                    push_sample($urandom_range(0, 1) ? ADC_MAX : 12'd0);
                    sent++;
                end
                default:
                begin
                    push_sample(SAMPLE_W'($urandom()));
                    sent++;
                end
            endcase
            if ($urandom_range(0, 199) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        logic [MV_W-1:0] r_scale;
        logic [MV_W-1:0] r_low;
        logic [MV_W-1:0] r_high;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        sample   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // warm-up over a partial window, then full scale and zero windows
        foreach (warmup[i])
            push_sample(warmup[i]);
        repeat (8) push_sample(ADC_MAX);
        repeat (8) push_sample(12'd0);
        random_samples(200);

        // fixed corner settings; the first runs with no idling at all
        for (int p = 0; p < FIXED_SETTINGS; p++)
        begin
            apply_setting(fixed_scale[p], fixed_low[p], fixed_high[p]);
            if (fixed_low[p] == fixed_high[p])
                write_reg(REG_SPARE, 13'd1234);
            steady <= (p == 0);
            random_samples(fixed_count[p]);
            steady <= 1'b0;
        end

        // random settings with ordered thresholds
        for (int p = 0; p < RANDOM_SETTINGS; p++)
        begin
            r_scale = ($urandom_range(0, 3) == 0) ? MV_W'($urandom_range(0, 8191)) :
                                                     MV_W'($urandom_range(1, 5000));
            r_low   = MV_W'($urandom_range(0, 4000));
            r_high  = MV_W'($urandom_range(r_low + 1, 5000));
            apply_setting(r_scale, r_low, r_high);
            random_samples(RANDOM_RUN_LEN);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d samples across %0d scale/threshold settings (zero, unity, full",
                 samples_sent, settings_used);
        $display("range scale; inverted and equal thresholds); %0d readings compared",
                 readings_checked);
        if (pending != 0)
            $error("%0d predicted readings never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("tb_adc_moving_average_duty_map: done, clean");
        else
            $display("tb_adc_moving_average_duty_map: done, errors");
        $finish;
    end

endmodule

@@ adc_moving_average_duty_map.f @@
+incdir+rtl
rtl/amd_pkg.sv
rtl/amd_fifo.sv
rtl/amd_front.sv
rtl/amd_back.sv
rtl/adc_moving_average_duty_map.sv
test/duty_map_checker.sv
test/tb_adc_moving_average_duty_map.sv
